// File: hdl/bsht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsht_pkg: shared types and codes for the box selection hit test
// Object kinds, register indexes and the front/back queue entry type.
// ----------------------------------------------------------------------------
package bsht_pkg;

    localparam int CW = 32;
    localparam int IW = 32;
    // register port byte address: four word registers
    localparam int AW = 4;

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_CIRCLE  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    localparam logic [1:0] REG_AX = 2'd0;
    localparam logic [1:0] REG_AY = 2'd1;
    localparam logic [1:0] REG_BX = 2'd2;
    localparam logic [1:0] REG_BY = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [IW-1:0]        object_id;
        logic signed [CW-1:0] coord_a;
        logic signed [CW-1:0] coord_b;
        logic signed [CW-1:0] coord_c;
        logic signed [CW-1:0] coord_d;
    } t_in_item;

    typedef struct packed {
        logic [IW-1:0] selected_id;
        logic [1:0]    selected_kind;
    } t_out_item;

    // rectangle ordered into min/max corners
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
    } t_rect;

endpackage
`default_nettype wire

// File: hdl/bsht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsht_front: classification stage
// Registers the item and resolves point, bbox reject and endpoint tests.
// ----------------------------------------------------------------------------
module bsht_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire bsht_pkg::t_in_item i_item,
    input  wire bsht_pkg::t_rect    i_rect,
    output logic              o_valid,
    output bsht_pkg::t_in_item o_item,
    output logic              o_early_hit,   // decided selected
    output logic              o_need_geom    // still needs edge/circle math
);
    logic signed [bsht_pkg::CW-1:0] w_xmax, w_xmin, w_ymax, w_ymin;
    logic w_in1, w_in2, w_rej;
    logic r_valid, r_hit, r_geom, n_hit, n_geom;
    bsht_pkg::t_in_item r_item;

    always_comb begin
        w_xmax = (i_item.coord_a > i_item.coord_c) ? i_item.coord_a : i_item.coord_c;
        w_xmin = (i_item.coord_a < i_item.coord_c) ? i_item.coord_a : i_item.coord_c;
        w_ymax = (i_item.coord_b > i_item.coord_d) ? i_item.coord_b : i_item.coord_d;
        w_ymin = (i_item.coord_b < i_item.coord_d) ? i_item.coord_b : i_item.coord_d;
        w_in1 = i_item.coord_a >= i_rect.x0 && i_item.coord_a <= i_rect.x1 &&
                i_item.coord_b >= i_rect.y0 && i_item.coord_b <= i_rect.y1;
        w_in2 = i_item.coord_c >= i_rect.x0 && i_item.coord_c <= i_rect.x1 &&
                i_item.coord_d >= i_rect.y0 && i_item.coord_d <= i_rect.y1;
        w_rej = w_xmax < i_rect.x0 || w_xmin > i_rect.x1 ||
                w_ymax < i_rect.y0 || w_ymin > i_rect.y1;
        n_hit  = 1'b0;
        n_geom = 1'b0;
        case (i_item.kind)
            bsht_pkg::KIND_POINT:   n_hit = w_in1;
            bsht_pkg::KIND_SEGMENT: begin
                n_hit  = !w_rej && (w_in1 || w_in2);
                n_geom = !w_rej && !w_in1 && !w_in2;
            end
            bsht_pkg::KIND_CIRCLE:  n_geom = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= i_item;
        r_hit  <= n_hit;
        r_geom <= n_geom;
    end

    assign o_valid     = r_valid;
    assign o_item      = r_item;
    assign o_early_hit = r_hit;
    assign o_need_geom = r_geom;

    property p_excl;
        @(posedge i_clk) disable iff (!i_rst_n) r_valid |-> !(r_hit && r_geom);
    endproperty
    a_excl: assert property (p_excl) else $error("hit and geom both set");
    a_kind3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.kind == bsht_pkg::KIND_NONE) |-> !r_hit && !r_geom)
        else $error("unknown kind classified");
    a_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.kind == bsht_pkg::KIND_POINT) |-> !r_geom)
        else $error("point sent to geometry");
endmodule
`default_nettype wire

// File: hdl/bsht_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsht_back: geometry pipeline
// Edge intersection and circle outline tests in four registered stages.
// ----------------------------------------------------------------------------
module bsht_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire bsht_pkg::t_in_item i_item,
    input  wire               i_early_hit,
    input  wire               i_need_geom,
    input  wire bsht_pkg::t_rect    i_rect,
    output logic              o_valid,
    output bsht_pkg::t_out_item o_item
);
    localparam int DW = bsht_pkg::CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;

    // stage 1: differences
    logic r1_v, r1_hit, r1_geom;
    logic [1:0] r1_kind;
    logic [bsht_pkg::IW-1:0] r1_id;
    logic signed [DW-1:0] r1_dx12, r1_dy12;
    logic signed [DW-1:0] r1_ex [4];   // edge dx34 per edge
    logic signed [DW-1:0] r1_ey [4];
    logic signed [DW-1:0] r1_gx [4];   // dx13
    logic signed [DW-1:0] r1_gy [4];
    logic signed [DW-1:0] r1_ndx, r1_ndy, r1_fdx, r1_fdy, r1_r;

    // stage 2: products
    logic r2_v, r2_hit, r2_geom;
    logic [1:0] r2_kind;
    logic [bsht_pkg::IW-1:0] r2_id;
    logic signed [PW-1:0] r2_p [4][6];
    logic signed [PW-1:0] r2_nx, r2_ny, r2_fx, r2_fy, r2_rr;

    // stage 3: sums
    logic r3_v, r3_hit, r3_geom;
    logic [1:0] r3_kind;
    logic [bsht_pkg::IW-1:0] r3_id;
    logic signed [SW-1:0] r3_den [4];
    logic signed [SW-1:0] r3_tn [4];
    logic signed [SW-1:0] r3_un [4];
    logic signed [SW-1:0] r3_near, r3_far, r3_rr;

    // stage 4: result
    logic r4_v;
    bsht_pkg::t_out_item r4_item;

    logic signed [bsht_pkg::CW-1:0] w_x3 [4], w_y3 [4], w_x4 [4], w_y4 [4];
    logic signed [bsht_pkg::CW-1:0] w_nx, w_ny, w_fx, w_fy;
    logic signed [DW-1:0] w_d0, w_d1;
    logic [3:0] w_ehit;
    logic w_sel;

    always_comb begin
        w_x3[0] = i_rect.x0; w_y3[0] = i_rect.y0; w_x4[0] = i_rect.x1; w_y4[0] = i_rect.y0;
        w_x3[1] = i_rect.x1; w_y3[1] = i_rect.y0; w_x4[1] = i_rect.x1; w_y4[1] = i_rect.y1;
        w_x3[2] = i_rect.x1; w_y3[2] = i_rect.y1; w_x4[2] = i_rect.x0; w_y4[2] = i_rect.y1;
        w_x3[3] = i_rect.x0; w_y3[3] = i_rect.y1; w_x4[3] = i_rect.x0; w_y4[3] = i_rect.y0;
        w_nx = (i_item.coord_a < i_rect.x0) ? i_rect.x0 :
               (i_item.coord_a > i_rect.x1) ? i_rect.x1 : i_item.coord_a;
        w_ny = (i_item.coord_b < i_rect.y0) ? i_rect.y0 :
               (i_item.coord_b > i_rect.y1) ? i_rect.y1 : i_item.coord_b;
        w_d0 = DW'(i_item.coord_a) - DW'(i_rect.x0);
        w_d1 = DW'(i_item.coord_a) - DW'(i_rect.x1);
        w_fx = ((w_d0 < 0 ? -w_d0 : w_d0) > (w_d1 < 0 ? -w_d1 : w_d1)) ? i_rect.x0 : i_rect.x1;
        w_d0 = DW'(i_item.coord_b) - DW'(i_rect.y0);
        w_d1 = DW'(i_item.coord_b) - DW'(i_rect.y1);
        w_fy = ((w_d0 < 0 ? -w_d0 : w_d0) > (w_d1 < 0 ? -w_d1 : w_d1)) ? i_rect.y0 : i_rect.y1;
    end

    always_ff @(posedge i_clk) begin
        r1_kind <= i_item.kind;
        r1_id   <= i_item.object_id;
        r1_hit  <= i_early_hit;
        r1_geom <= i_need_geom;
        r1_dx12 <= DW'(i_item.coord_a) - DW'(i_item.coord_c);
        r1_dy12 <= DW'(i_item.coord_b) - DW'(i_item.coord_d);
        for (int e = 0; e < 4; e++) begin
            r1_ex[e] <= DW'(w_x3[e]) - DW'(w_x4[e]);
            r1_ey[e] <= DW'(w_y3[e]) - DW'(w_y4[e]);
            r1_gx[e] <= DW'(i_item.coord_a) - DW'(w_x3[e]);
            r1_gy[e] <= DW'(i_item.coord_b) - DW'(w_y3[e]);
        end
        r1_ndx <= DW'(i_item.coord_a) - DW'(w_nx);
        r1_ndy <= DW'(i_item.coord_b) - DW'(w_ny);
        r1_fdx <= DW'(i_item.coord_a) - DW'(w_fx);
        r1_fdy <= DW'(i_item.coord_b) - DW'(w_fy);
        r1_r   <= DW'(i_item.coord_c);

        r2_kind <= r1_kind; r2_id <= r1_id; r2_hit <= r1_hit; r2_geom <= r1_geom;
        for (int e = 0; e < 4; e++) begin
            r2_p[e][0] <= r1_dx12 * r1_ey[e];
            r2_p[e][1] <= r1_dy12 * r1_ex[e];
            r2_p[e][2] <= r1_gx[e] * r1_ey[e];
            r2_p[e][3] <= r1_gy[e] * r1_ex[e];
            r2_p[e][4] <= r1_dx12 * r1_gy[e];
            r2_p[e][5] <= r1_dy12 * r1_gx[e];
        end
        r2_nx <= r1_ndx * r1_ndx;
        r2_ny <= r1_ndy * r1_ndy;
        r2_fx <= r1_fdx * r1_fdx;
        r2_fy <= r1_fdy * r1_fdy;
        r2_rr <= r1_r * r1_r;

        r3_kind <= r2_kind; r3_id <= r2_id; r3_hit <= r2_hit; r3_geom <= r2_geom;
        for (int e = 0; e < 4; e++) begin
            r3_den[e] <= SW'(r2_p[e][0]) - SW'(r2_p[e][1]);
            r3_tn[e]  <= SW'(r2_p[e][2]) - SW'(r2_p[e][3]);
            r3_un[e]  <= SW'(r2_p[e][5]) - SW'(r2_p[e][4]);
        end
        r3_near <= SW'(r2_nx) + SW'(r2_ny);
        r3_far  <= SW'(r2_fx) + SW'(r2_fy);
        r3_rr   <= SW'(r2_rr);

        r4_item.selected_id   <= r3_id;
        r4_item.selected_kind <= r3_kind;
    end

    always_comb begin
        for (int e = 0; e < 4; e++) begin
            if (r3_den[e] > 0)
                w_ehit[e] = r3_tn[e] >= 0 && r3_tn[e] <= r3_den[e] &&
                            r3_un[e] >= 0 && r3_un[e] <= r3_den[e];
            else if (r3_den[e] < 0)
                w_ehit[e] = r3_tn[e] <= 0 && r3_tn[e] >= r3_den[e] &&
                            r3_un[e] <= 0 && r3_un[e] >= r3_den[e];
            else
                w_ehit[e] = 1'b0;
        end
        w_sel = r3_hit;
        if (r3_geom) begin
            if (r3_kind == bsht_pkg::KIND_CIRCLE)
                w_sel = (r3_near <= r3_rr) && (r3_far > r3_rr);
            else
                w_sel = |w_ehit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v && w_sel;
        end
    end

    assign o_valid = r4_v;
    assign o_item  = r4_item;

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r3_v)) else $error("result without item");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.selected_kind != bsht_pkg::KIND_NONE)
        else $error("unknown kind selected");
    a_rr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> r3_rr >= 0) else $error("negative radius square");
endmodule
`default_nettype wire

// File: hdl/box_selection_hit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_selection_hit_test: rectangle selection of points, segments, circles
// o_valid strobes only for a selected item; the item passes the front register,
// then differences, products, sums; the compare feeds the result register.
// Throughput: one transaction per cycle; busy is never raised.
// The rate is set by the geometry pipeline: differences, products, sums, compare.
// Reset (synchronous, active low) clears the pipeline valids and corners to 0.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module box_selection_hit_test (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire bsht_pkg::t_in_item i_item,
    output logic                o_valid,
    output bsht_pkg::t_out_item o_item,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [bsht_pkg::AW-1:0] paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic signed [bsht_pkg::CW-1:0] r_ax, r_ay, r_bx, r_by;
    bsht_pkg::t_rect w_rect;
    logic w_wr;
    logic w_fv, w_fhit, w_fgeom;
    bsht_pkg::t_in_item w_fitem;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register file: corners, word addressed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0;
        end else if (w_wr) begin
            case (paddr[bsht_pkg::AW-1:2])
                bsht_pkg::REG_AX: r_ax <= pwdata;
                bsht_pkg::REG_AY: r_ay <= pwdata;
                bsht_pkg::REG_BX: r_bx <= pwdata;
                bsht_pkg::REG_BY: r_by <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[bsht_pkg::AW-1:2])
            bsht_pkg::REG_AX: prdata = r_ax;
            bsht_pkg::REG_AY: prdata = r_ay;
            bsht_pkg::REG_BX: prdata = r_bx;
            bsht_pkg::REG_BY: prdata = r_by;
            default:          prdata = '0;
        endcase
    end

    // Corner ordering into min/max
    always_comb begin
        w_rect.x0 = (r_ax < r_bx) ? r_ax : r_bx;
        w_rect.x1 = (r_ax < r_bx) ? r_bx : r_ax;
        w_rect.y0 = (r_ay < r_by) ? r_ay : r_by;
        w_rect.y1 = (r_ay < r_by) ? r_by : r_ay;
    end

    // Front: classify; its output register is the queue entry to the back
    bsht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_item     (i_item),
        .i_rect     (w_rect),
        .o_valid    (w_fv),
        .o_item     (w_fitem),
        .o_early_hit(w_fhit),
        .o_need_geom(w_fgeom)
    );

    // Back: geometry and result strobe
    bsht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_fv),
        .i_item     (w_fitem),
        .i_early_hit(w_fhit),
        .i_need_geom(w_fgeom),
        .i_rect     (w_rect),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );
endmodule
`default_nettype wire
